// ===== src/ppcm_pkg.sv =====
// ----------------------------------------------------------------------------
// ppcm_pkg
// Shared constants and types for the periodic point to cell mapper.
// ----------------------------------------------------------------------------
package ppcm_pkg;

	localparam int MAX_CELLS_DEF  = 64;
	localparam int COORD_BITS_DEF = 32;

	localparam int FIELD_W   = 32;
	localparam int CELL_W    = 7;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_BOX_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LO_X    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LO_Y    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_X = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y = 3'd7;

	localparam logic [FIELD_W-1:0] RST_BOX   = 32'd65536;
	localparam logic [FIELD_W-1:0] RST_LO    = 32'd0;
	localparam logic [FIELD_W-1:0] RST_SIZE  = 32'd32768;
	localparam logic [CELL_W-1:0]  RST_CELLS = 7'd2;

	typedef struct packed {
		logic below;
		logic above;
	} ring_t;

endpackage

// ===== src/ppcm_axis_front.sv =====
// ----------------------------------------------------------------------------
// ppcm_axis_front
// Per-axis window setup, periodic wrap, clamp and ghost-ring classification.
// ----------------------------------------------------------------------------
module ppcm_axis_front import ppcm_pkg::*; #(
	parameter int MAX_CELLS  = MAX_CELLS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int NB         = $clog2(MAX_CELLS + 1),
	parameter int QB         = $clog2(MAX_CELLS),
	parameter int DW         = COORD_BITS + QB
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [4:0]            en,
	input  logic [FIELD_W-1:0]    pos,
	input  logic [FIELD_W-1:0]    box,
	input  logic [FIELD_W-1:0]    lo,
	input  logic [FIELD_W-1:0]    size,
	input  logic [CELL_W-1:0]     cells,
	output logic [COORD_BITS-1:0] size_c,
	output logic [NB-1:0]         n_c,
	output ring_t                 ring,
	output logic [DW-1:0]         offset
);

	localparam int SW = COORD_BITS + NB + 2;
	localparam logic signed [SW-1:0] R_LEN  = SW'(COORD_BITS'(RST_BOX));
	localparam logic signed [SW-1:0] R_SIZE = SW'(COORD_BITS'(RST_SIZE));
	localparam logic signed [SW-1:0] R_LO   = SW'(COORD_BITS'(RST_LO));
	localparam logic signed [SW-1:0] R_PROD = R_SIZE * SW'(RST_CELLS);

	logic [COORD_BITS-1:0] box_w, lo_w, size_w;
	logic [NB-1:0]         n_w;
	logic signed [SW-1:0]  len_q, size_q, lo_q, prod_q, left_q, hi_q, right_q, rm1_q;
	logic [NB-1:0]         n_q;
	logic signed [SW-1:0]  v_s1, v_s2, v_s3, v_s4;
	ring_t                 ring_s5;
	logic [DW-1:0]         d_s5;

	always_comb begin
		box_w  = COORD_BITS'(box);
		lo_w   = COORD_BITS'(lo);
		size_w = COORD_BITS'(size);
		if (box_w == '0) box_w = COORD_BITS'(1);
		if (size_w == '0) size_w = COORD_BITS'(1);
		if (32'(cells) < 32'd2)
			n_w = NB'(2);
		else if (32'(cells) > 32'(MAX_CELLS))
			n_w = NB'(MAX_CELLS);
		else
			n_w = NB'(cells);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= R_LEN;
			size_q  <= R_SIZE;
			lo_q    <= R_LO;
			n_q     <= NB'(RST_CELLS);
			prod_q  <= R_PROD;
			left_q  <= R_LO - R_SIZE;
			hi_q    <= R_LO + R_PROD;
			right_q <= R_LO + R_PROD + R_SIZE;
			rm1_q   <= R_LO + R_PROD + R_SIZE - SW'(1);
		end else begin
			len_q   <= SW'(box_w);
			size_q  <= SW'(size_w);
			lo_q    <= SW'(lo_w);
			n_q     <= n_w;
			prod_q  <= SW'(size_w) * SW'(n_w);
			left_q  <= SW'(lo_w) - SW'(size_w);
			hi_q    <= lo_q + prod_q;
			right_q <= lo_q + prod_q + size_q;
			rm1_q   <= lo_q + prod_q + size_q - SW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) v_s1 <= SW'(COORD_BITS'(pos));
		if (en[1]) v_s2 <= (v_s1 < left_q) ? v_s1 + len_q : v_s1;
		if (en[2]) v_s3 <= (v_s2 >= right_q) ? v_s2 - len_q : v_s2;
		if (en[3]) begin
			if (v_s3 < left_q)
				v_s4 <= left_q;
			else if (v_s3 >= right_q)
				v_s4 <= rm1_q;
			else
				v_s4 <= v_s3;
		end
		if (en[4]) begin
			ring_s5.below <= v_s4 < lo_q;
			ring_s5.above <= v_s4 >= hi_q;
			d_s5          <= DW'(v_s4 - lo_q);
		end
	end

	assign size_c = COORD_BITS'(size_q);
	assign n_c    = n_q;
	assign ring   = ring_s5;
	assign offset = d_s5;

endmodule

// ===== src/ppcm_div_cell.sv =====
// ----------------------------------------------------------------------------
// ppcm_div_cell
// One restoring-division cell: resolves one quotient bit of offset / size.
// ----------------------------------------------------------------------------
module ppcm_div_cell import ppcm_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int QB         = $clog2(MAX_CELLS_DEF),
	parameter int K          = 0,
	parameter int DW         = COORD_BITS + QB
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [COORD_BITS-1:0] size,
	input  logic [DW-1:0]         r_in,
	input  logic [QB-1:0]         q_in,
	input  ring_t                 ring_in,
	output logic [DW-1:0]         r_out,
	output logic [QB-1:0]         q_out,
	output ring_t                 ring_out
);

	logic [DW-1:0] div_sh;
	logic          take;
	logic [DW-1:0] r_q;
	logic [QB-1:0] q_q;
	ring_t         ring_q;

	assign div_sh = DW'(size) << K;
	assign take   = r_in >= div_sh;

	always_ff @(posedge clk) begin
		if (en) begin
			r_q    <= take ? r_in - div_sh : r_in;
			q_q    <= q_in | (QB'(take) << K);
			ring_q <= ring_in;
		end
	end

	assign r_out    = r_q;
	assign q_out    = q_q;
	assign ring_out = ring_q;

endmodule

// ===== src/periodic_point_to_cell_mapper_core.sv =====
// ----------------------------------------------------------------------------
// periodic_point_to_cell_mapper_core
// Maps a global Q16.16 point to its cell in a local grid with a ghost ring.
// ----------------------------------------------------------------------------
// Input beats (pos_x, pos_y) arrive on in_valid/in_ready, result beats
// (cell_x, cell_y, on_ring) leave on out_valid/out_ready. One beat per clock
// is accepted and delivered when the sink keeps up.
// The pipeline has five stages of wrap, clamp and ring test, one
// restoring-division cell per quotient bit, and the output register.
// Configuration registers are written through cfg_we/cfg_idx/cfg_data;
// the user must write them only while the block is idle, which the block
// itself does not enforce. Derived window bounds are registered from them.
// Reset loads the default register values and empties the pipeline.
// When out_ready is low the pipeline keeps filling its empty stages, so
// in_ready drops only once every stage holds a beat.
// ----------------------------------------------------------------------------
module periodic_point_to_cell_mapper_core import ppcm_pkg::*; #(
	parameter int MAX_CELLS  = MAX_CELLS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [FIELD_W-1:0]   cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [FIELD_W-1:0]   pos_x,
	input  logic [FIELD_W-1:0]   pos_y,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CELL_W-1:0]    cell_x,
	output logic [CELL_W-1:0]    cell_y,
	output logic                 on_ring
);

	localparam int NB = $clog2(MAX_CELLS + 1);
	localparam int QB = $clog2(MAX_CELLS);
	localparam int DW = COORD_BITS + QB;
	localparam int NS = 5 + QB + 1;

	logic [FIELD_W-1:0] box_x_q, box_y_q, lo_x_q, lo_y_q, size_x_q, size_y_q;
	logic [CELL_W-1:0]  cells_x_q, cells_y_q;

	logic [NS-1:0] vld_q;
	logic [NS-1:0] en;

	logic [COORD_BITS-1:0] size_cx, size_cy;
	logic [NB-1:0]         n_x, n_y;
	ring_t                 rg_x [QB+1];
	ring_t                 rg_y [QB+1];
	logic [DW-1:0]         r_x  [QB+1];
	logic [DW-1:0]         r_y  [QB+1];
	logic [QB-1:0]         q_x  [QB+1];
	logic [QB-1:0]         q_y  [QB+1];

	logic [NB-1:0]     ix, iy;
	logic [CELL_W-1:0] cell_x_q, cell_y_q;
	logic              on_ring_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_x_q   <= RST_BOX;
			box_y_q   <= RST_BOX;
			lo_x_q    <= RST_LO;
			lo_y_q    <= RST_LO;
			size_x_q  <= RST_SIZE;
			size_y_q  <= RST_SIZE;
			cells_x_q <= RST_CELLS;
			cells_y_q <= RST_CELLS;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_BOX_X:   box_x_q   <= cfg_data;
				REG_BOX_Y:   box_y_q   <= cfg_data;
				REG_LO_X:    lo_x_q    <= cfg_data;
				REG_LO_Y:    lo_y_q    <= cfg_data;
				REG_SIZE_X:  size_x_q  <= cfg_data;
				REG_SIZE_Y:  size_y_q  <= cfg_data;
				REG_CELLS_X: cells_x_q <= CELL_W'(cfg_data);
				REG_CELLS_Y: cells_y_q <= CELL_W'(cfg_data);
				default: ;
			endcase
		end
	end

	always_comb begin
		en[NS-1] = !vld_q[NS-1] || out_ready;
		for (int j = NS - 2; j >= 0; j--) begin
			en[j] = !vld_q[j] || en[j+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= in_valid;
			for (int j = 1; j < NS; j++) begin
				if (en[j]) vld_q[j] <= vld_q[j-1];
			end
		end
	end

	assign in_ready = en[0];

	ppcm_axis_front #(
		.MAX_CELLS(MAX_CELLS), .COORD_BITS(COORD_BITS), .NB(NB), .QB(QB), .DW(DW)
	) u_front_x (
		.clk(clk), .arst_n(arst_n), .en(en[4:0]), .pos(pos_x), .box(box_x_q),
		.lo(lo_x_q), .size(size_x_q), .cells(cells_x_q), .size_c(size_cx),
		.n_c(n_x), .ring(rg_x[0]), .offset(r_x[0])
	);

	ppcm_axis_front #(
		.MAX_CELLS(MAX_CELLS), .COORD_BITS(COORD_BITS), .NB(NB), .QB(QB), .DW(DW)
	) u_front_y (
		.clk(clk), .arst_n(arst_n), .en(en[4:0]), .pos(pos_y), .box(box_y_q),
		.lo(lo_y_q), .size(size_y_q), .cells(cells_y_q), .size_c(size_cy),
		.n_c(n_y), .ring(rg_y[0]), .offset(r_y[0])
	);

	assign q_x[0] = '0;
	assign q_y[0] = '0;

	for (genvar k = 0; k < QB; k++) begin : g_div
		ppcm_div_cell #(
			.COORD_BITS(COORD_BITS), .QB(QB), .K(QB - 1 - k), .DW(DW)
		) u_cell_x (
			.clk(clk), .en(en[5+k]), .size(size_cx), .r_in(r_x[k]), .q_in(q_x[k]),
			.ring_in(rg_x[k]), .r_out(r_x[k+1]), .q_out(q_x[k+1]), .ring_out(rg_x[k+1])
		);
		ppcm_div_cell #(
			.COORD_BITS(COORD_BITS), .QB(QB), .K(QB - 1 - k), .DW(DW)
		) u_cell_y (
			.clk(clk), .en(en[5+k]), .size(size_cy), .r_in(r_y[k]), .q_in(q_y[k]),
			.ring_in(rg_y[k]), .r_out(r_y[k+1]), .q_out(q_y[k+1]), .ring_out(rg_y[k+1])
		);
	end

	always_comb begin
		ix = NB'(q_x[QB]) + NB'(1);
		iy = NB'(q_y[QB]) + NB'(1);
		if (ix > n_x) ix = n_x;
		if (iy > n_y) iy = n_y;
		if (rg_x[QB].below)
			ix = '0;
		else if (rg_x[QB].above)
			ix = n_x + NB'(1);
		if (rg_y[QB].below)
			iy = '0;
		else if (rg_y[QB].above)
			iy = n_y + NB'(1);
	end

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			cell_x_q  <= CELL_W'(ix);
			cell_y_q  <= CELL_W'(iy);
			on_ring_q <= rg_x[QB].below || rg_x[QB].above
				|| rg_y[QB].below || rg_y[QB].above;
		end
	end

	assign out_valid = vld_q[NS-1];
	assign cell_x    = cell_x_q;
	assign cell_y    = cell_y_q;
	assign on_ring   = on_ring_q;

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (&vld_q) && !out_ready)
		else $error("input stalled with a free stage");

	a_interior_x: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !on_ring |-> cell_x != '0 && cell_y != '0)
		else $error("interior result carries a ring index");

	a_ring_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (cell_x == '0 || cell_y == '0) |-> on_ring)
		else $error("low ring index without ring flag");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the periodic point to cell mapper core.
// ----------------------------------------------------------------------------
// A directed table walks the edges of the reset window, then phases rewrite
// every register (fixed sets, then random values) and stream points near
// and far from the window. Each untyped point is mapped by a local model of
// the wrap, clamp and binning rules, and every result beat is compared with
// the oldest pending cell. Both sides idle at random, with calm phases.
// ----------------------------------------------------------------------------
module tb_top;
	import ppcm_pkg::*;

	typedef struct packed {
		logic [CELL_W-1:0] cx;
		logic [CELL_W-1:0] cy;
		logic              ring;
	} cell_t;

	typedef struct {
		logic [FIELD_W-1:0] px;
		logic [FIELD_W-1:0] py;
		bit                 typed;
		cell_t              want;
	} row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = REG_BOX_X;
	logic [FIELD_W-1:0]   cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [FIELD_W-1:0]   pos_x = '0;
	logic [FIELD_W-1:0]   pos_y = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [CELL_W-1:0]    cell_x;
	logic [CELL_W-1:0]    cell_y;
	logic                 on_ring;

	logic [FIELD_W-1:0] box_len [2];
	logic [FIELD_W-1:0] lo_edge [2];
	logic [FIELD_W-1:0] csize   [2];
	logic [CELL_W-1:0]  ncells  [2];

	cell_t cell_due[$];
	int    errors = 0;
	bit    calm = 1'b0;

	periodic_point_to_cell_mapper_core DUT (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("FAIL periodic_point_to_cell_mapper_core");
		$finish;
	end

	// per-axis bin: index and ghost flag
	function automatic logic [CELL_W:0] bin_axis(logic [FIELD_W-1:0] p, int ax);
		longint len, sz, n, lo, v, hi, lft, rgt, idx;
		len = box_len[ax];
		sz  = csize[ax];
		n   = ncells[ax];
		lo  = lo_edge[ax];
		v   = p;
		if (len < 1) len = 1;
		if (sz < 1) sz = 1;
		if (n < 2) n = 2;
		if (n > MAX_CELLS_DEF) n = MAX_CELLS_DEF;
		hi  = lo + n * sz;
		lft = lo - sz;
		rgt = hi + sz;
		if (v < lft) v += len;
		if (v >= rgt) v -= len;
		if (v < lft) v = lft;
		if (v >= rgt) v = rgt - 1;
		if (v < lo) return {1'b1, 7'd0};
		if (v >= hi) return {1'b1, CELL_W'(n + 1)};
		idx = 1 + (v - lo) / sz;
		if (idx > n) idx = n;
		return {1'b0, CELL_W'(idx)};
	endfunction

	function automatic cell_t locate_cell(logic [FIELD_W-1:0] px, logic [FIELD_W-1:0] py);
		logic [CELL_W:0] bx, by;
		bx = bin_axis(px, 0);
		by = bin_axis(py, 1);
		return '{cx: bx[CELL_W-1:0], cy: by[CELL_W-1:0], ring: bx[CELL_W] | by[CELL_W]};
	endfunction

	task automatic report(string what, cell_t got, cell_t want);
		errors++;
		$display("[%0t] mismatch %s: got x=%0d y=%0d r=%0b want x=%0d y=%0d r=%0b",
			$realtime, what, got.cx, got.cy, got.ring, want.cx, want.cy, want.ring);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] data);
		cfg_we   = 1'b1;
		cfg_idx  = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_BOX_X:   box_len[0] = data;
			REG_BOX_Y:   box_len[1] = data;
			REG_LO_X:    lo_edge[0] = data;
			REG_LO_Y:    lo_edge[1] = data;
			REG_SIZE_X:  csize[0] = data;
			REG_SIZE_Y:  csize[1] = data;
			REG_CELLS_X: ncells[0] = data[CELL_W-1:0];
			REG_CELLS_Y: ncells[1] = data[CELL_W-1:0];
			default: ;
		endcase
	endtask

	task automatic send_point(logic [FIELD_W-1:0] px, logic [FIELD_W-1:0] py,
			bit typed, cell_t want);
		int gap;
		bit took;
		gap = calm ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		pos_x = px;
		pos_y = py;
		do begin
			@(posedge clk);
			took = in_ready;
			if (took) cell_due.insert(cell_due.size(), typed ? want : locate_cell(px, py));
			@(negedge clk);
		end while (!took);
	endtask

	// a coordinate near the window of one axis, or anywhere
	function automatic logic [FIELD_W-1:0] pick_pos(int ax);
		logic [FIELD_W-1:0] sz;
		int k;
		sz = (csize[ax] == 0) ? 32'd1 : csize[ax];
		k = $urandom_range(0, 9);
		if (k < 6)
			return lo_edge[ax] + ($urandom_range(0, ncells[ax] + 3) - 2) * sz
				+ $urandom % sz;
		if (k == 6) return lo_edge[ax] - box_len[ax] + $urandom_range(0, 3) - 1;
		if (k == 7) return lo_edge[ax] + box_len[ax] + $urandom_range(0, 3) - 1;
		return $urandom;
	endfunction

	function automatic logic [FIELD_W-1:0] pick_wide();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'hFFFF_FFFF;
			3: return $urandom_range(1, 1 << 20);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [FIELD_W-1:0] pick_count();
		logic [6:0] pool [8] = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd64, 7'd65, 7'd127, 7'd7};
		if ($urandom_range(0, 2) == 0) return $urandom;
		return {25'd0, pool[$urandom_range(0, 7)]};
	endfunction

	// result side
	initial begin
		int gap;
		bit got;
		cell_t seen, want;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = calm ? 0 : $urandom_range(0, 18);
			if (gap > 0) begin
				out_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready = 1'b1;
			do begin
				@(posedge clk);
				got = out_valid;
				if (got) begin
					seen = '{cx: cell_x, cy: cell_y, ring: on_ring};
					if (cell_due.size() == 0) begin
						report("unexpected beat", seen, seen);
					end else begin
						want = cell_due.pop_front();
						if (seen.cx !== want.cx) report("cell_x", seen, want);
						if (seen.cy !== want.cy) report("cell_y", seen, want);
						if (seen.ring !== want.ring) report("on_ring", seen, want);
					end
				end
				@(negedge clk);
			end while (!got);
		end
	end

	// stimulus
	initial begin
		row_t rows [12];
		logic [FIELD_W-1:0] vals [8];
		box_len = '{RST_BOX, RST_BOX};
		lo_edge = '{RST_LO, RST_LO};
		csize   = '{RST_SIZE, RST_SIZE};
		ncells  = '{RST_CELLS, RST_CELLS};
		// reset window per axis: [-0.5, 1.5), two cells of 0.5
		rows = '{
			'{32'h0000_0000, 32'h0000_0000, 1, '{7'd1, 7'd1, 1'b0}},
			'{32'h0000_8000, 32'h0000_7FFF, 1, '{7'd2, 7'd1, 1'b0}},
			'{32'h0000_FFFF, 32'h0000_8000, 1, '{7'd2, 7'd2, 1'b0}},
			'{32'hFFFF_FFFF, 32'h0000_0000, 1, '{7'd3, 7'd1, 1'b1}},
			'{32'h0000_0000, 32'hFFFF_FFFF, 1, '{7'd1, 7'd3, 1'b1}},
			'{32'h0001_0000, 32'h0000_4000, 0, '0},
			'{32'h0001_7FFF, 32'h0001_8000, 0, '0},
			'{32'h0001_8000, 32'h0000_C000, 0, '0},
			'{32'hAAAA_AAAA, 32'h5555_5555, 0, '0},
			'{32'h5555_5555, 32'hAAAA_AAAA, 0, '0},
			'{32'h0002_0000, 32'h0000_0001, 0, '0},
			'{32'h0000_0001, 32'h7FFF_FFFF, 0, '0}
		};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (3) @(negedge clk);

		foreach (rows[i]) send_point(rows[i].px, rows[i].py, rows[i].typed, rows[i].want);

		for (int ph = 0; ph < 13; ph++) begin
			in_valid = 1'b0;
			wait (cell_due.size() == 0);
			@(negedge clk);
			repeat (20) @(negedge clk);
			calm = (ph % 4 == 1);
			case (ph)
				0: vals = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
				1: vals = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
					32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
				2: vals = '{32'd65536, 32'h0100_0000, 32'h0000_8000, 32'h0080_0000,
					32'd1, 32'h0002_0000, 32'd64, 32'd64};
				default: begin
					for (int r = 0; r < 6; r++) vals[r] = pick_wide();
					vals[6] = pick_count();
					vals[7] = pick_count();
				end
			endcase
			for (int r = 0; r < 8; r++) write_reg(CFG_IDX_W'(r), vals[r]);
			repeat (4) @(negedge clk);
			for (int n = 0; n < 42; n++) send_point(pick_pos(0), pick_pos(1), 0, '0);
		end

		in_valid = 1'b0;
		wait (cell_due.size() == 0);
		repeat (30) @(negedge clk);
		if (errors == 0) begin
			$display("PASS periodic_point_to_cell_mapper_core");
		end else begin
			$display("FAIL periodic_point_to_cell_mapper_core");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/ppcm_pkg.sv
src/ppcm_axis_front.sv
src/ppcm_div_cell.sv
src/periodic_point_to_cell_mapper_core.sv
tb/tb_top.sv
